/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is active.
`define BIV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define BIV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/biv_pkg.sv */
// Boot image validator package: status codes, register indexes, config struct,
// CRC-32 byte update. Used by every module of the block.
`default_nettype none

package biv_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned VEC_BYTES = 8;
    localparam int unsigned VEC_W = VEC_BYTES * BYTE_W;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] MIN_LENGTH = WORD_W'(VEC_BYTES);
    localparam logic [1:0] STACK_ALIGN_MASK = 2'b11;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MCU = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_END = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_END = 3'd7;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_MAGIC   = 4'd1,
        ST_VERSION = 4'd2,
        ST_TARGET  = 4'd3,
        ST_SIZE    = 4'd4,
        ST_READ    = 4'd5,
        ST_CRC     = 4'd6,
        ST_STACK   = 4'd7,
        ST_RESET   = 4'd8
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] expected_magic;
        logic [WORD_W-1:0] expected_version;
        logic [WORD_W-1:0] target_mcu;
        logic [WORD_W-1:0] target_product;
        logic [WORD_W-1:0] app_base;
        logic [WORD_W-1:0] app_end;
        logic [WORD_W-1:0] ram_base;
        logic [WORD_W-1:0] ram_end;
    } t_cfg;

    // Reflected CRC-32, one byte: eight shift steps, flattens to an XOR network.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [WORD_W-1:0] c;
        c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/biv_cfg.sv */
// Configuration register file of the boot image validator.
// Depends on biv_pkg for the register indexes and the t_cfg struct.
`default_nettype none

module biv_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [biv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_cfg_data,
    output biv_pkg::t_cfg                       o_cfg
);
    import biv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:     n_cfg.expected_magic = i_cfg_data;
                CFG_VERSION:   n_cfg.expected_version = i_cfg_data;
                CFG_MCU:       n_cfg.target_mcu = i_cfg_data;
                CFG_PRODUCT:   n_cfg.target_product = i_cfg_data;
                CFG_APP_BASE:  n_cfg.app_base = i_cfg_data;
                CFG_APP_END:   n_cfg.app_end = i_cfg_data;
                CFG_RAM_BASE:  n_cfg.ram_base = i_cfg_data;
                CFG_RAM_END:   n_cfg.ram_end = i_cfg_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/boot_image_validator.sv */
// Boot image validator: takes one word per cycle, manifest or image byte, with
// no gaps needed between words. A result is held in an output register and
// shows in the cycle after the word that caused it; the next word is taken while
// that result waits, as long as the output register is empty or being read.
// The rate is one word per cycle while o_in_ready holds, set by the CRC-32 byte update
// and state update that each word passes through. Manifest failures and read
// errors report status with crc_value zero; the last image byte reports the
// CRC, stack pointer and reset vector checks. Depends on biv_pkg and biv_cfg.
`default_nettype none

module boot_image_validator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [biv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_func,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_image_magic,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_image_version,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_image_mcu,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_image_product,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_image_length,
    input  wire logic [biv_pkg::WORD_W-1:0]     i_image_checksum,
    input  wire logic [biv_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                           i_read_failed,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [3:0]                          o_status,
    output logic [biv_pkg::WORD_W-1:0]          o_crc_value
);
    import biv_pkg::*;

    t_cfg cfg;

    biv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // streaming state
    logic              r_phase, n_phase;
    logic [WORD_W-1:0] r_crc, n_crc;
    logic [WORD_W-1:0] r_seen, n_seen;
    logic [WORD_W-1:0] r_len, n_len;
    logic [WORD_W-1:0] r_chk, n_chk;
    logic [VEC_W-1:0]  r_vec, n_vec;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [WORD_W-1:0] r_out_crc;

    logic              accept;
    logic              res_valid;
    t_status           res_status;
    logic [WORD_W-1:0] res_crc;

    logic [WORD_W-1:0] area;
    logic [WORD_W-1:0] seen_inc;
    logic [WORD_W-1:0] crc_step;
    logic [WORD_W-1:0] crc_final;
    logic [WORD_W-1:0] msp;
    logic [WORD_W-1:0] rst_vec;
    logic [WORD_W-1:0] rst_addr;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept = i_in_valid && o_in_ready;

    assign area = cfg.app_end - cfg.app_base;
    assign seen_inc = r_seen + WORD_W'(1);
    assign crc_step = crc_byte(r_crc, i_data_byte);
    assign crc_final = crc_step ^ CRC_XOROUT;

    always_comb begin
        n_phase = r_phase;
        n_crc = r_crc;
        n_seen = r_seen;
        n_len = r_len;
        n_chk = r_chk;
        n_vec = r_vec;
        res_valid = 1'b0;
        res_status = ST_OK;
        res_crc = '0;

        // capture the vector table bytes as they pass
        if (r_seen[WORD_W-1:3] == '0) begin
            for (int k = 0; k < VEC_BYTES; k++) begin
                if (r_seen[2:0] == 3'(k)) begin
                    n_vec[k*BYTE_W +: BYTE_W] = i_data_byte;
                end
            end
        end
        msp = n_vec[WORD_W-1:0];
        rst_vec = n_vec[VEC_W-1:WORD_W];
        rst_addr = {rst_vec[WORD_W-1:1], 1'b0};

        if (!accept) begin
            n_vec = r_vec;
        end else if (!i_func) begin
            // manifest: restart, then check fields in order
            n_phase = 1'b0;
            n_crc = CRC_INIT;
            n_seen = '0;
            n_vec = '0;
            n_len = i_image_length;
            n_chk = i_image_checksum;
            res_valid = 1'b1;
            if (i_image_magic != cfg.expected_magic) begin
                res_status = ST_MAGIC;
            end else if (i_image_version != cfg.expected_version) begin
                res_status = ST_VERSION;
            end else if (i_image_mcu != cfg.target_mcu ||
                         i_image_product != cfg.target_product) begin
                res_status = ST_TARGET;
            end else if (i_image_length < MIN_LENGTH || i_image_length > area) begin
                res_status = ST_SIZE;
            end else begin
                res_valid = 1'b0;
                n_phase = 1'b1;
            end
        end else if (!r_phase) begin
            // drop bytes outside a validation
            n_vec = r_vec;
        end else if (i_read_failed) begin
            n_vec = r_vec;
            n_phase = 1'b0;
            res_valid = 1'b1;
            res_status = ST_READ;
        end else begin
            n_crc = crc_step;
            n_seen = seen_inc;
            if (seen_inc == r_len) begin
                n_phase = 1'b0;
                res_valid = 1'b1;
                res_crc = crc_final;
                if (crc_final != r_chk) begin
                    res_status = ST_CRC;
                end else if (msp < cfg.ram_base || msp > cfg.ram_end ||
                             (msp[1:0] & STACK_ALIGN_MASK) != 2'b00) begin
                    res_status = ST_STACK;
                end else if (!rst_vec[0] || rst_addr < cfg.app_base ||
                             rst_addr >= cfg.app_end) begin
                    res_status = ST_RESET;
                end else begin
                    res_status = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_crc <= CRC_INIT;
            r_seen <= '0;
            r_len <= '0;
            r_chk <= '0;
            r_vec <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_crc <= n_crc;
            r_seen <= n_seen;
            r_len <= n_len;
            r_chk <= n_chk;
            r_vec <= n_vec;
            if (accept && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output word, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_status <= res_status;
            r_out_crc <= res_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_crc_value = r_out_crc;

endmodule

`default_nettype wire

/* rtl/biv_checker.sv */
// Port-level checker for boot_image_validator, attached by bind.
// Depends on biv_pkg for status codes and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module biv_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [3:0]                  o_status,
    input wire logic [biv_pkg::WORD_W-1:0]  o_crc_value
);
    import biv_pkg::*;

    // hold a stalled result word
    `BIV_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_crc_value), "stalled result changed")

    `BIV_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result present after reset")

    `BIV_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    // early failures carry no CRC
    `BIV_ASSERT(a_early_crc_zero, i_clk, i_rst_n, o_out_valid && (o_status == ST_MAGIC || o_status == ST_VERSION || o_status == ST_TARGET || o_status == ST_SIZE || o_status == ST_READ) |-> o_crc_value == '0, "nonzero CRC on early failure")

    `BIV_ASSERT(a_result_has_cause, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_rst_n), "result without accepted word")

endmodule

bind boot_image_validator biv_checker u_biv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_crc_value (o_crc_value)
);

`default_nettype wire
